/* rtl/core/cmc_pkg.sv */
// ----------------------------------------------------------------------------
// cmc_pkg - shared definitions for the counter-mode S-box cipher unit
// Nibble S-box, round constants, counter base and the round function.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned NBytes  = 8;
  localparam int unsigned VbW     = 4;
  localparam int unsigned IdxW    = 28;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned MaxRnds = 32;

  localparam logic [DataW-1:0] CtrBase = 64'h0001_0203_0405_0607;

  // register select, taken from paddr bit 3
  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cmc_reg_e;

  function automatic logic [3:0] cmc_sbox(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'h6;
      4'h1: r = 4'hB;
      4'h2: r = 4'h5;
      4'h3: r = 4'h4;
      4'h4: r = 4'h2;
      4'h5: r = 4'hE;
      4'h6: r = 4'h7;
      4'h7: r = 4'hA;
      4'h8: r = 4'h9;
      4'h9: r = 4'hD;
      4'hA: r = 4'hF;
      4'hB: r = 4'hC;
      4'hC: r = 4'h3;
      4'hD: r = 4'h1;
      4'hE: r = 4'h0;
      default: r = 4'h8;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmc_rcon(input logic [4:0] r);
    logic [7:0] c;
    case (r)
      5'd0:  c = 8'h01;
      5'd1:  c = 8'h03;
      5'd2:  c = 8'h07;
      5'd3:  c = 8'h0F;
      5'd4:  c = 8'h1F;
      5'd5:  c = 8'h3E;
      5'd6:  c = 8'h7D;
      5'd7:  c = 8'hFB;
      5'd8:  c = 8'hF7;
      5'd9:  c = 8'hEF;
      5'd10: c = 8'hDF;
      5'd11: c = 8'hBF;
      5'd12: c = 8'h7F;
      5'd13: c = 8'hFE;
      5'd14: c = 8'hFD;
      5'd15: c = 8'hFA;
      5'd16: c = 8'hF5;
      5'd17: c = 8'hEB;
      5'd18: c = 8'hD7;
      5'd19: c = 8'hAF;
      5'd20: c = 8'h5F;
      5'd21: c = 8'hBE;
      5'd22: c = 8'h7C;
      5'd23: c = 8'hF8;
      5'd24: c = 8'hF1;
      5'd25: c = 8'hE3;
      5'd26: c = 8'hC7;
      5'd27: c = 8'h8F;
      5'd28: c = 8'h1E;
      5'd29: c = 8'h3C;
      5'd30: c = 8'h78;
      default: c = 8'hF0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cmc_sub_byte(input logic [7:0] b);
    return {cmc_sbox(b[7:4]), cmc_sbox(b[3:0])};
  endfunction

  // One round: substitute, add key byte, mix neighbouring words, add constant.
  function automatic logic [DataW-1:0] cmc_round(input logic [DataW-1:0] s,
                                                 input logic [7:0]       rk,
                                                 input logic [7:0]       rc);
    logic [15:0]      t [4];
    logic [DataW-1:0] o;
    for (int i = 0; i < 4; i++) begin
      t[i] = {cmc_sub_byte(s[16*i+8 +: 8]) ^ rk,
              cmc_sub_byte(s[16*i   +: 8]) ^ {4'h0, rk[7:4]}};
    end
    o[15:0]  = t[0] ^ t[1] ^ {8'h00, rc};
    o[31:16] = t[1] ^ t[2];
    o[47:32] = t[2] ^ t[3];
    o[63:48] = t[3] ^ t[0];
    return o;
  endfunction

endpackage

/* rtl/core/ctr_mode_64bit_sbox_cipher_unit.sv */
// ----------------------------------------------------------------------------
// ctr_mode_64bit_sbox_cipher_unit - counter-mode block encryptor
// Encrypts one 8-byte block per item with a pipelined S-box cipher whose
// keystream comes from the block index added to a fixed counter base.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-------------------------------
//  input     | in        | in_valid_i/in_stall_o | data_in_i, valid_bytes_i,
//            |           |                       | block_index_i
//  output    | out       | out_valid_o/out_stall_i | data_out_o
//  config    | in/out    | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
//  The pipeline has one counter stage, one stage per cipher round, and the
//  output register. One item is taken every cycle while the skid is empty.
//  Reset clears the key registers and all valid bits; payload registers are
//  left unreset. An item arriving while the output is stalled spills into a
//  one-entry skid register; while that is full the whole pipeline holds and
//  in_stall_o is high: a register, so no stall ripples through the pipeline.
//
module ctr_mode_64bit_sbox_cipher_unit #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cmc_pkg::DataW-1:0]     data_in_i,
  input  logic [cmc_pkg::VbW-1:0]       valid_bytes_i,
  input  logic [cmc_pkg::IdxW-1:0]      block_index_i,
  // output item channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cmc_pkg::DataW-1:0]     data_out_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmc_pkg::PaddrW-1:0]    paddr,
  input  logic [cmc_pkg::KeyW-1:0]      pwdata,
  output logic [cmc_pkg::KeyW-1:0]      prdata,
  output logic                          pready
);
  import cmc_pkg::*;

  // --------------------------------------------------------------------------
  // Key registers
  // --------------------------------------------------------------------------
  logic [KeyW-1:0] key_low_q, key_low_d;
  logic [KeyW-1:0] key_high_q, key_high_d;
  logic            cfg_wr;
  cmc_reg_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cmc_reg_e'(paddr[3]);

  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_KEY_LOW:  key_low_d  = pwdata;
        REG_KEY_HIGH: key_high_d = pwdata;
        default:      key_low_d  = key_low_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      default:      prdata = key_low_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
    end
  end

  logic [2*KeyW-1:0] key_all;
  assign key_all = {key_high_q, key_low_q};

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the skid is full
  // --------------------------------------------------------------------------
  logic skid_valid_q, skid_valid_d;
  logic pipe_en;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // --------------------------------------------------------------------------
  // Counter stage: form the counter, reverse its bytes into cipher order,
  // and work out which bytes get the keystream
  // --------------------------------------------------------------------------
  logic [DataW-1:0]  ctr;
  logic [DataW-1:0]  ctr_swap;
  logic [NBytes-1:0] byte_mask;

  assign ctr = CtrBase + {{(DataW-IdxW){1'b0}}, block_index_i};

  always_comb begin
    for (int j = 0; j < NBytes; j++) begin
      ctr_swap[8*j +: 8] = ctr[8*(NBytes-1-j) +: 8];
      // bytes below valid_bytes; counts above eight cover the whole block
      byte_mask[j]       = (valid_bytes_i > VbW'(j));
    end
  end

  // stage k holds the state after k rounds
  logic [ROUNDS:0]   vld_q;
  logic [DataW-1:0]  st_q   [ROUNDS+1];
  logic [DataW-1:0]  dat_q  [ROUNDS+1];
  logic [NBytes-1:0] msk_q  [ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (pipe_en) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st_q[0]  <= ctr_swap;
      dat_q[0] <= data_in_i;
      msk_q[0] <= byte_mask;
    end
  end

  // --------------------------------------------------------------------------
  // Round stages: one cipher round per register stage
  // --------------------------------------------------------------------------
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int unsigned KIdx = r % 16;
    logic [7:0]       rk;
    logic [DataW-1:0] nxt;

    assign rk  = key_all[8*KIdx +: 8];
    assign nxt = cmc_round(st_q[r], rk, cmc_rcon(5'(r % MaxRnds)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r+1] <= 1'b0;
      end else if (pipe_en) begin
        vld_q[r+1] <= vld_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        st_q[r+1]  <= nxt;
        dat_q[r+1] <= dat_q[r];
        msk_q[r+1] <= msk_q[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Keystream apply, output register and skid
  // --------------------------------------------------------------------------
  logic [DataW-1:0] ks_mask;
  logic [DataW-1:0] res;
  logic             res_valid;

  always_comb begin
    for (int j = 0; j < NBytes; j++) begin
      ks_mask[8*j +: 8] = {8{msk_q[ROUNDS][j]}};
    end
  end

  assign res       = dat_q[ROUNDS] ^ (st_q[ROUNDS] & ks_mask);
  assign res_valid = pipe_en && vld_q[ROUNDS];

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic [DataW-1:0] skid_data_q, skid_data_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid first; the pipeline is held this cycle
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_data_d  = res;
      end
    end else if (res_valid) begin
      // hold the stalled item, park the arriving one
      skid_valid_d = 1'b1;
      skid_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

/* tb/ctr_mode_64bit_sbox_cipher_unit_test.sv */
// ----------------------------------------------------------------------------
// ctr_mode_64bit_sbox_cipher_unit_test - self-checking bench for the CTR unit
// Drives 8-byte blocks with byte counts and block indexes through the unit,
// predicts each ciphertext from its own model of the 32-round S-box cipher
// and the two key registers, and compares every output item in order under
// random stalls on both channels, a long output hold-off and key changes.
// ----------------------------------------------------------------------------
module ctr_mode_64bit_sbox_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cmc_pkg::*;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned MaxReported = 10;

  // counter base: bytes 00..07, most significant first
  localparam logic [63:0] CounterBase = 64'h0001_0203_0405_0607;
  // nibble substitution, entry n at bits 4n+3..4n
  localparam logic [63:0] SboxNibbles = 64'h8013_CFD9_A7E2_45B6;
  // round constants, round r at bits 8r+7..8r
  localparam logic [255:0] RoundConsts =
    256'hF0783C1E8FC7E3F1_F87CBE5FAFD7EBF5_FAFDFE7FBFDFEFF7_FB7D3E1F0F070301;

  typedef struct {
    logic [DataW-1:0] plain;
    logic [VbW-1:0]   nbytes;
    logic [IdxW-1:0]  blk;
    logic [DataW-1:0] cipher;
  } block_expect_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [DataW-1:0]   data_in_i;
  logic [VbW-1:0]     valid_bytes_i;
  logic [IdxW-1:0]    block_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [DataW-1:0]   data_out_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [KeyW-1:0]    pwdata;
  logic [KeyW-1:0]    prdata;
  logic               pready;

  // our copy of the key registers
  logic [KeyW-1:0]    key_lo_q;
  logic [KeyW-1:0]    key_hi_q;

  block_expect_t      pending_blocks_q[$];

  int unsigned        error_count;
  int unsigned        blocks_sent;
  int unsigned        blocks_checked;
  int unsigned        key_writes;
  int unsigned        input_stall_cycles;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        hold_left;

  ctr_mode_64bit_sbox_cipher_unit #(
    .ROUNDS(NumRounds)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_in_i    (data_in_i),
    .valid_bytes_i(valid_bytes_i),
    .block_index_i(block_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] sbox_byte(input logic [7:0] b);
    return {SboxNibbles[4*b[7:4] +: 4], SboxNibbles[4*b[3:0] +: 4]};
  endfunction

  // key byte for a round: bytes 0..7 from the low word, 8..15 from the high,
  // wrapping every sixteen rounds
  function automatic logic [7:0] round_key_byte(input int unsigned rnd);
    int unsigned kb;
    kb = rnd % 16;
    return (kb < 8) ? key_lo_q[8*kb +: 8] : key_hi_q[8*(kb-8) +: 8];
  endfunction

  function automatic logic [63:0] ctr_keystream(input logic [IdxW-1:0] blk);
    logic [63:0] ctr;
    logic [63:0] st;
    logic [15:0] t [4];
    logic [7:0]  rk;
    logic [7:0]  rc;
    ctr = CounterBase + {36'd0, blk};
    // counter bytes, most significant first, become state bytes 0..7
    for (int j = 0; j < 8; j++) begin
      st[8*j +: 8] = ctr[8*(7-j) +: 8];
    end
    for (int r = 0; r < NumRounds; r++) begin
      rk = round_key_byte(r);
      rc = RoundConsts[8*(r % 32) +: 8];
      for (int i = 0; i < 4; i++) begin
        t[i] = {sbox_byte(st[16*i+8 +: 8]) ^ rk,
                sbox_byte(st[16*i +: 8]) ^ {4'h0, rk[7:4]}};
      end
      st[15:0]  = t[0] ^ t[1] ^ {8'h00, rc};
      st[31:16] = t[1] ^ t[2];
      st[47:32] = t[2] ^ t[3];
      st[63:48] = t[3] ^ t[0];
    end
    return st;
  endfunction

  // counts above eight encrypt the whole block, zero leaves it untouched
  function automatic logic [63:0] encrypt_block(input logic [DataW-1:0] plain,
                                                input logic [VbW-1:0]   nbytes,
                                                input logic [IdxW-1:0]  blk);
    logic [63:0] mask;
    int unsigned n;
    n = (nbytes > 8) ? 8 : nbytes;
    mask = '0;
    for (int j = 0; j < 8; j++) begin
      if (j < n) mask[8*j +: 8] = 8'hFF;
    end
    return plain ^ (ctr_keystream(blk) & mask);
  endfunction

  function automatic void note_error(input string msg);
    if (error_count < MaxReported) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, optional long hold-off, in-order compare
  // ---------------------------------------------------------------------------

  initial begin
    block_expect_t e;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        // hold off until the count runs out
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_blocks_q.size() == 0) begin
          note_error($sformatf("unexpected output item data_out=%h", data_out_o));
        end else begin
          e = pending_blocks_q.pop_front();
          blocks_checked++;
          if (data_out_o !== e.cipher) begin
            note_error($sformatf(
              "data_out mismatch: data_in=%h bytes=%0d index=%h exp=%h got=%h",
              e.plain, e.nbytes, e.blk, e.cipher, data_out_o));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_block(input logic [DataW-1:0] plain,
                            input logic [VbW-1:0]   nbytes,
                            input logic [IdxW-1:0]  blk);
    block_expect_t e;
    data_in_i     = plain;
    valid_bytes_i = nbytes;
    block_index_i = blk;
    in_valid_i    = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    e.plain  = plain;
    e.nbytes = nbytes;
    e.blk    = blk;
    e.cipher = encrypt_block(plain, nbytes, blk);
    pending_blocks_q.push_back(e);
    blocks_sent++;
    @(negedge clk_i);
    // leave valid high for the next item unless a gap is drawn
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
  endtask

  // drop valid and wait until every expected item has come out
  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (pending_blocks_q.size() != 0) @(negedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic write_key(input cmc_reg_e sel, input logic [KeyW-1:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {sel, 3'b000};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (sel == REG_KEY_LOW) key_lo_q = val;
    else                    key_hi_q = val;
    key_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_keys(input logic [KeyW-1:0] lo, input logic [KeyW-1:0] hi);
    wait_drain();
    write_key(REG_KEY_LOW, lo);
    write_key(REG_KEY_HIGH, hi);
  endtask

  // a well-formed message: indexes from zero, full blocks, last block of 1..8 bytes
  task automatic send_message(output int unsigned count);
    int unsigned len;
    logic [VbW-1:0] nb;
    len = $urandom_range(12, 1);
    for (int unsigned b = 0; b < len; b++) begin
      nb = (b == len - 1) ? VbW'($urandom_range(8, 1)) : VbW'(8);
      send_block({$urandom, $urandom}, nb, IdxW'(b));
    end
    count = len;
  endtask

  // anything the fields allow, including zero and over-eight byte counts
  task automatic send_noise();
    logic [DataW-1:0] d;
    case ($urandom_range(3))
      0:       d = '0;
      1:       d = '1;
      default: d = {$urandom, $urandom};
    endcase
    send_block(d, VbW'($urandom_range(15)), IdxW'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // zero key after reset; field extremes and every byte count
  task automatic test_field_extremes();
    send_block('0, 4'd8, '0);
    send_block('1, 4'd8, '1);
    send_block('1, 4'd1, '0);
    for (int unsigned n = 0; n < 16; n++) begin
      send_block(64'h0123_4567_89AB_CDEF, VbW'(n), IdxW'(n * 28'h0111_1111));
    end
    wait_drain();
  endtask

  // extreme and patterned keys, so both key halves and every round byte vary
  task automatic test_key_extremes();
    logic [KeyW-1:0] lo [6];
    logic [KeyW-1:0] hi [6];
    lo[0] = '1;                    hi[0] = '1;
    lo[1] = '1;                    hi[1] = '0;
    lo[2] = '0;                    hi[2] = '1;
    lo[3] = 64'hAAAA_AAAA_AAAA_AAAA; hi[3] = 64'h5555_5555_5555_5555;
    lo[4] = 64'h0706_0504_0302_0100; hi[4] = 64'h0F0E_0D0C_0B0A_0908;
    lo[5] = {$urandom, $urandom};  hi[5] = {$urandom, $urandom};
    for (int k = 0; k < 6; k++) begin
      set_keys(lo[k], hi[k]);
      send_block('0, 4'd8, '0);
      send_block('1, 4'd8, '1);
      send_block({$urandom, $urandom}, 4'd5, IdxW'($urandom));
    end
    wait_drain();
  endtask

  // hold the output long enough to fill the pipeline and stall the input,
  // then pause the sender until everything has drained
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 3 * NumRounds + 20;
    for (int unsigned i = 0; i < 70; i++) send_noise();
    wait_drain();
  endtask

  // messages and noise in three idling phases, a fresh key for each
  task automatic test_random_traffic(input int unsigned per_phase);
    int unsigned done;
    int unsigned got;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 24; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      set_keys({$urandom, $urandom}, {$urandom, $urandom});
      done = 0;
      while (done < per_phase) begin
        if ($urandom_range(99) < 80) begin
          send_message(got);
          done += got;
        end else begin
          send_noise();
          done++;
        end
      end
    end
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_in_i     = '0;
    valid_bytes_i = '0;
    block_index_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    key_lo_q      = '0;
    key_hi_q      = '0;
    error_count   = 0;
    blocks_sent   = 0;
    blocks_checked = 0;
    key_writes    = 0;
    input_stall_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_key_extremes();
    test_backpressure();
    test_random_traffic(340);

    // let any stray output item show up before the verdict
    wait_drain();
    repeat (NumRounds + 8) @(negedge clk_i);
    if (pending_blocks_q.size() != 0) begin
      note_error($sformatf("%0d expected items never came out", pending_blocks_q.size()));
    end

    $display("Covered %0d blocks (%0d checked) over %0d key writes,",
             blocks_sent, blocks_checked, key_writes);
    $display("byte counts 0..15, index extremes, %0d input stall cycles.",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
